// ----- hw/rtl/ffua_pkg.sv -----
// ----------------------------------------------------------------------------
// ffua_pkg
// Shared widths, opcodes and the owner RAM write bundle for the allocator.
// ----------------------------------------------------------------------------
package ffua_pkg;

  localparam int SIZE_W  = 11;
  localparam int OWNER_W = 10;
  localparam int START_W = 10;
  localparam int FREED_W = 11;
  localparam int REG_W   = 11;

  localparam logic [REG_W-1:0] UNITS_RESET = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               we;
    logic [OWNER_W-1:0] data;
  } ram_wr_t;

endpackage

// ----- hw/rtl/first_fit_unit_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_core
// First-fit contiguous allocator over a per-unit owner map held in one RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// success, start_unit and freed_units for the single cycle that done is high,
// and must be captured then since it cannot be held off. All timing comes
// from the owner RAM port, one unit per cycle: an allocate scans the active
// pool until it finds a run and then writes the run one unit per cycle. A
// free scans the whole pool. Bad owners and zero-size allocates skip the
// scan and pass through the report state. After reset the block clears the
// owner RAM with busy high; the cfg_we / cfg_wdata register write is taken
// at any time.
module first_fit_unit_allocator_core #(
  parameter int unsigned POOL_UNITS = 1024,
  parameter int unsigned MAX_OWNER  = 1023
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic [ffua_pkg::SIZE_W-1:0]      request_size,
  input  logic [ffua_pkg::OWNER_W-1:0]     owner_id,
  input  logic                             cfg_we,
  input  logic [ffua_pkg::REG_W-1:0]       cfg_wdata,
  output logic                             done,
  output logic                             success,
  output logic [ffua_pkg::START_W-1:0]     start_unit,
  output logic [ffua_pkg::FREED_W-1:0]     freed_units
);

  localparam int AW = $clog2(POOL_UNITS);
  localparam int LW = $clog2(POOL_UNITS + 1);
  localparam int CW = (LW > ffua_pkg::REG_W) ? LW : ffua_pkg::REG_W;

  logic [ffua_pkg::REG_W-1:0]    units_in_use;
  logic [CW-1:0]                 units_ext;
  logic [LW-1:0]                 limit;

  logic [AW-1:0]                 ram_raddr;
  logic [AW-1:0]                 ram_waddr;
  logic [ffua_pkg::OWNER_W-1:0]  ram_rdata;
  ffua_pkg::ram_wr_t             ram_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      units_in_use <= ffua_pkg::UNITS_RESET;
    end else if (cfg_we) begin
      units_in_use <= cfg_wdata;
    end
  end

  // zero acts as one unit, anything past the pool as the full pool
  assign units_ext = CW'(units_in_use);
  always_comb begin
    if (units_ext == '0) begin
      limit = LW'(1);
    end else if (units_ext > CW'(POOL_UNITS)) begin
      limit = LW'(POOL_UNITS);
    end else begin
      limit = LW'(units_ext);
    end
  end

  ffua_seq #(
    .POOL_UNITS (POOL_UNITS),
    .MAX_OWNER  (MAX_OWNER),
    .AW         (AW),
    .LW         (LW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .request_size (request_size),
    .owner_id     (owner_id),
    .limit        (limit),
    .busy         (busy),
    .done         (done),
    .success      (success),
    .start_unit   (start_unit),
    .freed_units  (freed_units),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .ram_waddr    (ram_waddr),
    .ram_wr       (ram_wr)
  );

  ffua_ram #(
    .DEPTH (POOL_UNITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .waddr (ram_waddr),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- hw/rtl/ffua_ram.sv -----
// ----------------------------------------------------------------------------
// ffua_ram
// Owner map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffua_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                             clk,
  input  logic [AW-1:0]                    waddr,
  input  ffua_pkg::ram_wr_t                wr,
  input  logic [AW-1:0]                    raddr,
  output logic [ffua_pkg::OWNER_W-1:0]     rdata
);

  logic [ffua_pkg::OWNER_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ffua_seq.sv -----
// ----------------------------------------------------------------------------
// ffua_seq
// Request sequencer: clearing pass, owner map scan, run fill and result.
// ----------------------------------------------------------------------------
module ffua_seq #(
  parameter int unsigned POOL_UNITS = 1024,
  parameter int unsigned MAX_OWNER  = 1023,
  parameter int          AW         = 10,
  parameter int          LW         = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             op,
  input  logic [ffua_pkg::SIZE_W-1:0]      request_size,
  input  logic [ffua_pkg::OWNER_W-1:0]     owner_id,
  input  logic [LW-1:0]                    limit,
  output logic                             busy,
  output logic                             done,
  output logic                             success,
  output logic [ffua_pkg::START_W-1:0]     start_unit,
  output logic [ffua_pkg::FREED_W-1:0]     freed_units,
  output logic [AW-1:0]                    ram_raddr,
  input  logic [ffua_pkg::OWNER_W-1:0]     ram_rdata,
  output logic [AW-1:0]                    ram_waddr,
  output ffua_pkg::ram_wr_t                ram_wr
);

  localparam int CW = (LW > ffua_pkg::SIZE_W) ? LW : ffua_pkg::SIZE_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_REPORT
  } state_t;

  state_t                         state;
  logic [LW-1:0]                  ptr;
  logic                           dvalid;
  logic [AW-1:0]                  didx;
  logic                           op_q;
  logic [ffua_pkg::SIZE_W-1:0]    size_q;
  logic [ffua_pkg::OWNER_W-1:0]   id_q;
  logic [LW-1:0]                  lim_q;
  logic [LW-1:0]                  run;
  logic [AW-1:0]                  run_start;
  logic [LW-1:0]                  cnt;
  logic [AW-1:0]                  wptr;

  logic issue;
  logic unit_free;
  logic run_hit;
  logic id_ok;

  assign busy      = (state != S_IDLE);
  assign issue     = (state == S_SCAN) && (ptr < lim_q);
  assign ram_raddr = ptr[AW-1:0];
  assign unit_free = (ram_rdata == '0);
  assign run_hit   = ((CW'(run) + CW'(1)) == CW'(size_q));
  assign id_ok     = (owner_id != '0) && (32'(owner_id) <= 32'(MAX_OWNER));

  always_comb begin
    ram_wr    = '0;
    ram_waddr = ptr[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_wr.we = 1'b1;
      end
      S_SCAN: begin
        // free: drop ownership of the unit read back last cycle
        ram_waddr = didx;
        ram_wr.we = (op_q == ffua_pkg::OP_FREE) && dvalid && (ram_rdata == id_q);
      end
      S_FILL: begin
        ram_waddr    = wptr;
        ram_wr.we    = 1'b1;
        ram_wr.data  = id_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      ptr    <= '0;
      dvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + LW'(1);
          if (ptr == LW'(POOL_UNITS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q   <= op;
            size_q <= request_size;
            id_q   <= owner_id;
            lim_q  <= (op == ffua_pkg::OP_FREE) ? LW'(POOL_UNITS) : limit;
            ptr    <= '0;
            dvalid <= 1'b0;
            run    <= '0;
            cnt    <= '0;
            if (!id_ok || (op == ffua_pkg::OP_ALLOC && request_size == '0)) begin
              success     <= (op == ffua_pkg::OP_FREE);
              start_unit  <= '0;
              freed_units <= '0;
              state       <= S_REPORT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          dvalid <= issue;
          didx   <= ptr[AW-1:0];
          if (issue) begin
            ptr <= ptr + LW'(1);
          end
          if (op_q == ffua_pkg::OP_FREE) begin
            if (dvalid && ram_rdata == id_q) begin
              cnt <= cnt + LW'(1);
            end
            if (!issue && !dvalid) begin
              done        <= 1'b1;
              success     <= 1'b1;
              start_unit  <= '0;
              freed_units <= ffua_pkg::FREED_W'(cnt);
              state       <= S_IDLE;
            end
          end else begin
            if (dvalid) begin
              if (unit_free) begin
                run <= run + LW'(1);
                if (run == '0) begin
                  run_start <= didx;
                end
                if (run_hit) begin
                  wptr  <= (run == '0) ? didx : run_start;
                  cnt   <= LW'(size_q);
                  state <= S_FILL;
                end
              end else begin
                run <= '0;
              end
            end else if (!issue) begin
              done        <= 1'b1;
              success     <= 1'b0;
              start_unit  <= '0;
              freed_units <= '0;
              state       <= S_IDLE;
            end
          end
        end
        S_FILL: begin
          wptr <= wptr + AW'(1);
          cnt  <= cnt - LW'(1);
          if (run == LW'(1)) begin
            run_start <= wptr;
          end
          if (cnt == LW'(1)) begin
            done        <= 1'b1;
            success     <= 1'b1;
            start_unit  <= ffua_pkg::START_W'((run == LW'(1)) ? wptr : run_start);
            freed_units <= '0;
            state       <= S_IDLE;
          end
        end
        S_REPORT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/ffua_checker.sv -----
// ----------------------------------------------------------------------------
// ffua_checker
// Port-level checks on the allocator's command and result timing.
// ----------------------------------------------------------------------------
module ffua_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             done,
  input  logic                             success,
  input  logic [ffua_pkg::START_W-1:0]     start_unit,
  input  logic [ffua_pkg::FREED_W-1:0]     freed_units
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not occupy the block");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (start_unit == '0 && freed_units == '0))
    else $error("failed allocate carries nonzero fields");

  a_free_fields: assert property (@(posedge clk) disable iff (rst)
    (done && freed_units != '0) |-> (success && start_unit == '0))
    else $error("free result carries a start unit or failure");

endmodule

bind first_fit_unit_allocator_core ffua_checker u_ffua_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .success     (success),
  .start_unit  (start_unit),
  .freed_units (freed_units)
);

// ----- bench/tb_first_fit_unit_allocator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_unit_allocator_core
// Self-checking bench for the first-fit unit allocator. Requests go in over
// start/busy from a pending queue. A shadow owner map predicts each answer,
// and every done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_first_fit_unit_allocator_core;

  localparam int unsigned POOL_UNITS = 1024;
  localparam int unsigned MAX_OWNER  = 1023;
  localparam longint      CYCLE_LIMIT = 6_000_000;
  localparam int          SETTLE_CYCLES = 2100;

  typedef struct {
    logic                         op;
    logic [ffua_pkg::SIZE_W-1:0]  size;
    logic [ffua_pkg::OWNER_W-1:0] owner;
  } unit_req_t;

  typedef struct {
    logic                         success;
    logic [ffua_pkg::START_W-1:0] start_unit;
    logic [ffua_pkg::FREED_W-1:0] freed;
  } unit_resp_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         op = ffua_pkg::OP_ALLOC;
  logic [ffua_pkg::SIZE_W-1:0]  request_size = '0;
  logic [ffua_pkg::OWNER_W-1:0] owner_id = '0;
  logic                         cfg_we = 1'b0;
  logic [ffua_pkg::REG_W-1:0]   cfg_wdata = '0;
  logic                         busy;
  logic                         done;
  logic                         success;
  logic [ffua_pkg::START_W-1:0] start_unit;
  logic [ffua_pkg::FREED_W-1:0] freed_units;

  // shadow of the block: per-unit owners and the pool size register
  logic [ffua_pkg::OWNER_W-1:0] shadow_owner [POOL_UNITS];
  logic [ffua_pkg::REG_W-1:0]   shadow_units = ffua_pkg::UNITS_RESET;

  unit_req_t  pending_reqs [$];
  unit_resp_t expected_resps [$];

  int     n_accepted = 0;
  int     seen_accepted = 0;
  int     burst_left = 1;
  int     gap_left = 0;
  int     n_errors = 0;
  longint n_cycles = 0;

  first_fit_unit_allocator_core #(
    .POOL_UNITS (POOL_UNITS),
    .MAX_OWNER  (MAX_OWNER)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .request_size (request_size),
    .owner_id     (owner_id),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .success      (success),
    .start_unit   (start_unit),
    .freed_units  (freed_units)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned active_units();
    int unsigned u;
    u = shadow_units;
    if (u < 1) u = 1;
    if (u > POOL_UNITS) u = POOL_UNITS;
    return u;
  endfunction

  // First fit over the shadow map; free scans the whole map, not just the
  // active part, so units stranded above a shrunk pool still get released.
  function automatic unit_resp_t predict_grant(unit_req_t rq);
    unit_resp_t  rs;
    int unsigned limit;
    int unsigned run;
    int unsigned first;
    bit          found;
    bit          id_ok;
    rs.success    = 1'b0;
    rs.start_unit = '0;
    rs.freed      = '0;
    id_ok = (rq.owner != 0) && (rq.owner <= MAX_OWNER);
    if (rq.op == ffua_pkg::OP_ALLOC) begin
      limit = active_units();
      run   = 0;
      first = 0;
      found = 1'b0;
      if (rq.size != 0 && id_ok) begin
        for (int i = 0; i < limit && !found; i++) begin
          if (shadow_owner[i] == '0) begin
            run++;
            if (run == rq.size) begin
              first = i + 1 - rq.size;
              found = 1'b1;
            end
          end else begin
            run = 0;
          end
        end
        if (found) begin
          for (int k = 0; k < rq.size; k++) shadow_owner[first + k] = rq.owner;
          rs.success    = 1'b1;
          rs.start_unit = first[ffua_pkg::START_W-1:0];
        end
      end
    end else begin
      rs.success = 1'b1;
      if (id_ok) begin
        for (int i = 0; i < POOL_UNITS; i++) begin
          if (shadow_owner[i] == rq.owner) begin
            shadow_owner[i] = '0;
            rs.freed = rs.freed + 1'b1;
          end
        end
      end
    end
    return rs;
  endfunction

  task automatic note_failure(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  initial begin
    for (int i = 0; i < POOL_UNITS; i++) shadow_owner[i] = '0;
  end

  // driver: bursts of items with random gaps, fields change on falling edges
  always @(negedge clk) begin
    if (n_accepted != seen_accepted) begin
      seen_accepted = n_accepted;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 8);
        case ($urandom_range(0, 7))
          0, 1, 2: gap_left = 0;
          3:       gap_left = $urandom_range(20, 60);
          default: gap_left = $urandom_range(1, 10);
        endcase
      end
    end
    if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      start        <= 1'b1;
      op           <= pending_reqs[0].op;
      request_size <= pending_reqs[0].size;
      owner_id     <= pending_reqs[0].owner;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check the result first, then take in a newly accepted item
  always @(posedge clk) begin
    unit_req_t  rq;
    unit_resp_t exp;
    if (!rst && done) begin
      if (expected_resps.size() == 0) begin
        note_failure($sformatf("result with none expected: success=%0d start=%0d freed=%0d",
                               success, start_unit, freed_units));
      end else begin
        exp = expected_resps.pop_front();
        if (success !== exp.success || start_unit !== exp.start_unit ||
            freed_units !== exp.freed) begin
          note_failure($sformatf({"mismatch: expected success=%0d start=%0d freed=%0d, ",
                                  "got success=%0d start=%0d freed=%0d"},
                                 exp.success, exp.start_unit, exp.freed,
                                 success, start_unit, freed_units));
        end
      end
    end
    if (!rst && start && !busy) begin
      rq.op    = op;
      rq.size  = request_size;
      rq.owner = owner_id;
      void'(pending_reqs.pop_front());
      expected_resps = {expected_resps, predict_grant(rq)};
      n_accepted++;
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_req(input logic o, input int unsigned sz, input int unsigned id);
    unit_req_t rq;
    rq.op    = o;
    rq.size  = sz[ffua_pkg::SIZE_W-1:0];
    rq.owner = id[ffua_pkg::OWNER_W-1:0];
    pending_reqs = {pending_reqs, rq};
  endtask

  // mostly small allocations from a handful of owners so that the pool fills,
  // fragments and drains; now and then any size or owner at all
  task automatic queue_random_req();
    int unsigned act;
    int unsigned sz;
    int unsigned id;
    act = active_units();
    if ($urandom_range(0, 9) == 0) id = $urandom_range(0, 1023);
    else id = $urandom_range(1, 12);
    case ($urandom_range(0, 19))
      0:       sz = $urandom_range(0, 2047);
      1, 2:    sz = $urandom_range(1, act);
      default: sz = $urandom_range(1, (act / 6 > 1) ? act / 6 : 1);
    endcase
    if ($urandom_range(0, 99) < 25) queue_req(ffua_pkg::OP_FREE, $urandom_range(0, 2047), id);
    else queue_req(ffua_pkg::OP_ALLOC, sz, id);
  endtask

  task automatic write_units(input logic [ffua_pkg::REG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_units = v;
    @(posedge clk);
  endtask

  task automatic drain_all();
    while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [ffua_pkg::REG_W-1:0] units_val;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full pool: edge sizes, bad owners, fill and empty, first-fit hole reuse
    write_units(11'd1024);
    queue_req(ffua_pkg::OP_ALLOC, 0, 1);
    queue_req(ffua_pkg::OP_ALLOC, 4, 0);
    queue_req(ffua_pkg::OP_FREE, 0, 0);
    queue_req(ffua_pkg::OP_ALLOC, 2047, 1);
    queue_req(ffua_pkg::OP_ALLOC, 1024, 1023);
    queue_req(ffua_pkg::OP_ALLOC, 1, 2);
    queue_req(ffua_pkg::OP_FREE, 2047, 1023);
    queue_req(ffua_pkg::OP_ALLOC, 1, 1);
    queue_req(ffua_pkg::OP_ALLOC, 3, 2);
    queue_req(ffua_pkg::OP_ALLOC, 2, 1);
    queue_req(ffua_pkg::OP_FREE, 0, 2);
    queue_req(ffua_pkg::OP_ALLOC, 4, 3);
    queue_req(ffua_pkg::OP_ALLOC, 3, 4);
    queue_req(ffua_pkg::OP_FREE, 5, 5);
    queue_req(ffua_pkg::OP_ALLOC, 512, 682);
    queue_req(ffua_pkg::OP_ALLOC, 502, 341);
    queue_req(ffua_pkg::OP_ALLOC, 1, 6);
    drain_all();

    // shrunk pool: units above it stay owned, free still counts them
    write_units(11'd8);
    queue_req(ffua_pkg::OP_FREE, 0, 1);
    queue_req(ffua_pkg::OP_ALLOC, 2, 7);
    queue_req(ffua_pkg::OP_ALLOC, 3, 7);
    queue_req(ffua_pkg::OP_FREE, 1365, 682);
    drain_all();

    // zero register acts as a one-unit pool
    write_units(11'd0);
    queue_req(ffua_pkg::OP_FREE, 0, 7);
    queue_req(ffua_pkg::OP_ALLOC, 1, 9);
    queue_req(ffua_pkg::OP_ALLOC, 1, 9);
    drain_all();

    // oversized register acts as the full pool
    write_units(11'd2047);
    queue_req(ffua_pkg::OP_ALLOC, 1000, 10);
    queue_req(ffua_pkg::OP_FREE, 0, 341);
    queue_req(ffua_pkg::OP_ALLOC, 1000, 10);
    drain_all();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       units_val = 11'd1;
        1:       units_val = 11'd16;
        2:       units_val = 11'd1024;
        3:       units_val = 11'd0;
        4:       units_val = 11'd2047;
        5:       units_val = ffua_pkg::REG_W'($urandom_range(2, 64));
        6:       units_val = ffua_pkg::REG_W'($urandom_range(1, 1024));
        default: units_val = ffua_pkg::REG_W'($urandom_range(0, 2047));
      endcase
      write_units(units_val);
      for (int n = 0; n < 70; n++) queue_random_req();
      drain_all();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_resps.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_resps.size()));
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
